FILE: src/mrli_pkg.sv
// Package for the two-way motor relay interlock.
// Mode and event codes, register map, reset values and shared structs.
// No dependencies.
`default_nettype none

package mrli_pkg;

  localparam int CFG_W  = 16;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_UP   = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;
  localparam logic [1:0] MODE_WAIT = 2'd3;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_UP   = 2'd1;
  localparam logic [1:0] OP_DOWN = 2'd2;
  localparam logic [1:0] OP_LOCK = 2'd3;

  // register select is byte address bit 2
  localparam logic REG_WATCHDOG = 1'b0;
  localparam logic REG_DEAD     = 1'b1;

  localparam logic [CFG_W-1:0] WATCHDOG_RESET = 16'd500;
  localparam logic [CFG_W-1:0] DEAD_RESET     = 16'd250;

  typedef struct packed {
    logic [CFG_W-1:0] watchdog_limit_ms;
    logic [CFG_W-1:0] dead_time_ms;
  } cfg_t;

  typedef struct packed {
    logic       up_drive;
    logic       down_drive;
    logic [1:0] mode;
    logic       locked;
  } res_t;

endpackage

`default_nettype wire

FILE: src/mrli_if.sv
// Valid/ready channel interfaces for the motor relay interlock.
// Command channel carries op and value; result channel carries drives, mode and lock.
// No dependencies.
`default_nettype none

interface mrli_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface mrli_res_if;
  logic       valid;
  logic       ready;
  logic       up_drive;
  logic       down_drive;
  logic [1:0] mode;
  logic       locked;

  modport source (output valid, output up_drive, output down_drive, output mode,
                  output locked, input ready);
  modport sink   (input valid, input up_drive, input down_drive, input mode,
                  input locked, output ready);
endinterface

`default_nettype wire

FILE: src/mrli_cfg_regs.sv
// APB-style configuration registers: watchdog limit and dead time.
// Depends on mrli_pkg.
`default_nettype none

module mrli_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrli_pkg::ADDR_W-1:0] paddr,
  input  logic [mrli_pkg::DATA_W-1:0] pwdata,
  output logic [mrli_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output mrli_pkg::cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.watchdog_limit_ms <= mrli_pkg::WATCHDOG_RESET;
      cfg.dead_time_ms      <= mrli_pkg::DEAD_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        mrli_pkg::REG_WATCHDOG: cfg.watchdog_limit_ms <= pwdata[mrli_pkg::CFG_W-1:0];
        mrli_pkg::REG_DEAD:     cfg.dead_time_ms      <= pwdata[mrli_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mrli_pkg::REG_WATCHDOG:
        prdata = {{(mrli_pkg::DATA_W-mrli_pkg::CFG_W){1'b0}}, cfg.watchdog_limit_ms};
      mrli_pkg::REG_DEAD:
        prdata = {{(mrli_pkg::DATA_W-mrli_pkg::CFG_W){1'b0}}, cfg.dead_time_ms};
      default:
        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/mrli_core.sv
// Interlock state update and result register.
// Holds mode, elapsed count and lock flag; depends on mrli_pkg.
`default_nettype none

module mrli_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  mrli_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_op,
  input  logic           in_value,
  output logic           out_valid,
  input  logic           out_ready,
  output mrli_pkg::res_t out_res
);

  localparam int CMP_W = (COUNT_WIDTH > mrli_pkg::CFG_W) ? COUNT_WIDTH : mrli_pkg::CFG_W;

  logic [1:0]             run_mode, run_mode_next;
  logic [COUNT_WIDTH-1:0] elapsed_ms, elapsed_ms_next, count_inc;
  logic                   lock_flag, lock_flag_next;
  logic [1:0]             dir;
  logic                   in_fire;

  assign in_ready = ~out_valid | out_ready;
  assign in_fire  = in_valid & in_ready;

  always_comb begin
    run_mode_next   = run_mode;
    elapsed_ms_next = elapsed_ms;
    lock_flag_next  = lock_flag;
    dir             = (in_op == mrli_pkg::OP_UP) ? mrli_pkg::MODE_UP : mrli_pkg::MODE_DOWN;
    count_inc       = (&elapsed_ms) ? elapsed_ms : elapsed_ms + 1'b1;
    case (in_op)
      mrli_pkg::OP_TICK: begin
        elapsed_ms_next = count_inc;
        if (run_mode inside {mrli_pkg::MODE_UP, mrli_pkg::MODE_DOWN}) begin
          if (CMP_W'(count_inc) > CMP_W'(cfg.watchdog_limit_ms)) begin
            run_mode_next   = mrli_pkg::MODE_WAIT;
            elapsed_ms_next = '0;
          end
        end else if (run_mode == mrli_pkg::MODE_WAIT) begin
          if (CMP_W'(count_inc) > CMP_W'(cfg.dead_time_ms)) begin
            run_mode_next = mrli_pkg::MODE_IDLE;
          end
        end
      end
      mrli_pkg::OP_UP, mrli_pkg::OP_DOWN: begin
        if (lock_flag || !in_value) begin
          run_mode_next   = mrli_pkg::MODE_WAIT;
          elapsed_ms_next = '0;
        end else if (run_mode == mrli_pkg::MODE_IDLE) begin
          run_mode_next   = dir;
          elapsed_ms_next = '0;
        end else if (run_mode == dir) begin
          elapsed_ms_next = '0;
        end
      end
      mrli_pkg::OP_LOCK: begin
        lock_flag_next = in_value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode   <= mrli_pkg::MODE_IDLE;
      elapsed_ms <= '0;
      lock_flag  <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (in_fire) begin
        run_mode   <= run_mode_next;
        elapsed_ms <= elapsed_ms_next;
        lock_flag  <= lock_flag_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res.up_drive   <= (run_mode_next == mrli_pkg::MODE_UP);
      out_res.down_drive <= (run_mode_next == mrli_pkg::MODE_DOWN);
      out_res.mode       <= run_mode_next;
      out_res.locked     <= lock_flag_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/two_way_motor_relay_interlock_top.sv
// Top level of the two-way motor relay interlock.
// Instantiates mrli_cfg_regs and mrli_core; depends on mrli_pkg and mrli_if.
`default_nettype none

// One command or tick is transferred per clock cycle and its result appears in the
// result register on the next cycle. The state update and the result register share
// one stage, so the command channel stays ready except when a held result is not
// taken. Registers may be written through the APB port only while the block is idle.
module two_way_motor_relay_interlock_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  mrli_cmd_if.sink                    cmd,
  mrli_res_if.source                  res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrli_pkg::ADDR_W-1:0] paddr,
  input  logic [mrli_pkg::DATA_W-1:0] pwdata,
  output logic [mrli_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  mrli_pkg::cfg_t cfg;
  mrli_pkg::res_t res_q;

  mrli_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mrli_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .in_op     (cmd.op),
    .in_value  (cmd.value),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_res   (res_q)
  );

  assign res.up_drive   = res_q.up_drive;
  assign res.down_drive = res_q.down_drive;
  assign res.mode       = res_q.mode;
  assign res.locked     = res_q.locked;

`ifndef SYNTHESIS
  a_no_both_drives: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.up_drive && res.down_drive))
    else $error("both relay drives on");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |-> !cmd.ready)
    else $error("command taken while result held");

  a_lock_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && cmd.op == mrli_pkg::OP_LOCK)
      |=> (res.valid && res.locked == $past(cmd.value)))
    else $error("lock transfer not reflected in result");
`endif

endmodule

`default_nettype wire
